// ----- hw/rtl/tiad_pkg.sv -----
// ----------------------------------------------------------------------------
// tiad_pkg
// Types and constants shared by the tilt and impact accident detector:
// transfer payloads, accident mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tiad_pkg;

   localparam int G_W     = 14;
   localparam int TILT_W  = 11;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0]            mode_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // accident mode codes
   localparam mode_type MODE_NONE    = 2'd0;
   localparam mode_type MODE_MOVING  = 2'd1;
   localparam mode_type MODE_STOPPED = 2'd2;

   // item kinds
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CANCEL = 1'b1;

   // register indexes
   localparam csr_idx_type CSR_IMPACT_THRESHOLD   = 3'd0;
   localparam csr_idx_type CSR_TILT_THRESHOLD     = 3'd1;
   localparam csr_idx_type CSR_MOVING_QUALIFY_MS  = 3'd2;
   localparam csr_idx_type CSR_STOPPED_QUALIFY_MS = 3'd3;
   localparam csr_idx_type CSR_MOVING_WINDOW_MS   = 3'd4;
   localparam csr_idx_type CSR_STOPPED_WINDOW_MS  = 3'd5;

   // register reset values
   localparam logic [G_W-1:0]    RST_IMPACT_THRESHOLD   = 14'd4000;
   localparam logic [TILT_W-1:0] RST_TILT_THRESHOLD     = 11'd450;
   localparam logic [TIME_W-1:0] RST_MOVING_QUALIFY_MS  = 32'd3000;
   localparam logic [TIME_W-1:0] RST_STOPPED_QUALIFY_MS = 32'd90000;
   localparam logic [TIME_W-1:0] RST_MOVING_WINDOW_MS   = 32'd90000;
   localparam logic [TIME_W-1:0] RST_STOPPED_WINDOW_MS  = 32'd30000;

   typedef struct packed {
      logic               action;
      logic [TIME_W-1:0]  now_ms;
      logic [G_W-1:0]     g_milli;
      logic [TILT_W-1:0]  tilt_decideg;
   } req_type;

   typedef struct packed {
      logic      buzzer_on;
      logic      detected_now;
      logic      alert_now;
      mode_type  accident_mode;
      logic      confirmed;
   } rsp_type;

endpackage

// ----- hw/rtl/tilt_impact_accident_detector.sv -----
// ----------------------------------------------------------------------------
// tilt_impact_accident_detector
// Pipeline: each request passes the input register, then the result
// register. Throughput: one item per cycle while rsp_ready does not stall
// the result register; the input register refills in the same cycle the
// result register is loaded or taken.
// Reset: synchronous, clears detection state and loads register defaults.
// Detects moving (impact plus tilt) and stopped (tilt only) accidents, runs
// the cancel window and raises a one-shot alert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_impact_accident_detector
   import tiad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_idx_type            csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [G_W-1:0]    impact_threshold_ff;
   logic [TILT_W-1:0] tilt_threshold_ff;
   logic [TIME_W-1:0] moving_qualify_ff;
   logic [TIME_W-1:0] stopped_qualify_ff;
   logic [TIME_W-1:0] moving_window_ff;
   logic [TIME_W-1:0] stopped_window_ff;

   // detection state
   logic              moving_running_ff, moving_running_in;
   logic [TIME_W-1:0] moving_start_ff, moving_start_in;
   logic              stopped_running_ff, stopped_running_in;
   logic [TIME_W-1:0] stopped_start_ff, stopped_start_in;
   logic              triggered_ff, triggered_in;
   mode_type          mode_ff, mode_in;
   logic [TIME_W-1:0] window_start_ff, window_start_in;
   logic              confirmed_ff, confirmed_in;

   // pipeline registers
   logic              s1_valid_ff;
   req_type           s1_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              s1_advance;

   // datapath terms
   logic              hard_impact;
   logic              tilted;
   logic              moving_cond;
   logic              stopped_cond;
   logic [TIME_W-1:0] moving_start_eff;
   logic [TIME_W-1:0] stopped_start_eff;
   logic [TIME_W-1:0] moving_elapsed;
   logic [TIME_W-1:0] stopped_elapsed;
   logic [TIME_W-1:0] window_elapsed_old;
   logic              moving_hit;
   logic              stopped_hit;
   logic              window_expired;
   logic [TIME_W-1:0] window_len;

   // handshake: result register drains or is empty, input register follows
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         impact_threshold_ff <= RST_IMPACT_THRESHOLD;
         tilt_threshold_ff   <= RST_TILT_THRESHOLD;
         moving_qualify_ff   <= RST_MOVING_QUALIFY_MS;
         stopped_qualify_ff  <= RST_STOPPED_QUALIFY_MS;
         moving_window_ff    <= RST_MOVING_WINDOW_MS;
         stopped_window_ff   <= RST_STOPPED_WINDOW_MS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMPACT_THRESHOLD:   impact_threshold_ff <= csr_data[G_W-1:0];
            CSR_TILT_THRESHOLD:     tilt_threshold_ff   <= csr_data[TILT_W-1:0];
            CSR_MOVING_QUALIFY_MS:  moving_qualify_ff   <= csr_data[TIME_W-1:0];
            CSR_STOPPED_QUALIFY_MS: stopped_qualify_ff  <= csr_data[TIME_W-1:0];
            CSR_MOVING_WINDOW_MS:   moving_window_ff    <= csr_data[TIME_W-1:0];
            CSR_STOPPED_WINDOW_MS:  stopped_window_ff   <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // classify the sample and measure hold times
   assign hard_impact  = s1_data_ff.g_milli > impact_threshold_ff;
   assign tilted       = s1_data_ff.tilt_decideg > tilt_threshold_ff;
   assign moving_cond  = hard_impact && tilted;
   assign stopped_cond = tilted && !hard_impact;

   assign moving_start_eff  = moving_running_ff  ? moving_start_ff  : s1_data_ff.now_ms;
   assign stopped_start_eff = stopped_running_ff ? stopped_start_ff : s1_data_ff.now_ms;
   assign moving_elapsed     = s1_data_ff.now_ms - moving_start_eff;
   assign stopped_elapsed    = s1_data_ff.now_ms - stopped_start_eff;
   assign window_elapsed_old = s1_data_ff.now_ms - window_start_ff;

   assign moving_hit  = moving_cond && !triggered_ff &&
                        (moving_elapsed >= moving_qualify_ff);
   assign stopped_hit = stopped_cond && !triggered_ff && !moving_hit &&
                        (stopped_elapsed >= stopped_qualify_ff);

   // compute next state and the result of the item in the input register
   always_comb begin
      moving_running_in  = moving_running_ff;
      moving_start_in    = moving_start_ff;
      stopped_running_in = stopped_running_ff;
      stopped_start_in   = stopped_start_ff;
      triggered_in       = triggered_ff;
      mode_in            = mode_ff;
      window_start_in    = window_start_ff;
      confirmed_in       = confirmed_ff;
      window_len         = moving_window_ff;
      window_expired     = 1'b0;
      rsp_data_in        = '0;

      priority if (s1_data_ff.action == ACTION_CANCEL) begin
         // drop all accident state
         moving_running_in  = 1'b0;
         moving_start_in    = '0;
         stopped_running_in = 1'b0;
         stopped_start_in   = '0;
         triggered_in       = 1'b0;
         mode_in            = MODE_NONE;
         window_start_in    = '0;
         confirmed_in       = 1'b0;
      end else if (confirmed_ff) begin
         // hold everything once confirmed
         rsp_data_in.accident_mode = mode_ff;
         rsp_data_in.confirmed     = 1'b1;
      end else begin
         moving_running_in  = moving_cond;
         moving_start_in    = moving_cond ? moving_start_eff : '0;
         stopped_running_in = stopped_cond;
         stopped_start_in   = stopped_cond ? stopped_start_eff : '0;

         if (moving_hit || stopped_hit) begin
            triggered_in    = 1'b1;
            mode_in         = moving_hit ? MODE_MOVING : MODE_STOPPED;
            window_start_in = s1_data_ff.now_ms;
         end

         // check the cancel window; a fresh detection starts at zero elapsed
         window_len = (mode_in == MODE_MOVING) ? moving_window_ff : stopped_window_ff;
         if (moving_hit || stopped_hit) begin
            window_expired = (window_len == '0);
         end else begin
            window_expired = triggered_ff && (window_elapsed_old >= window_len);
         end
         confirmed_in = window_expired;

         rsp_data_in.buzzer_on     = triggered_in && !window_expired;
         rsp_data_in.detected_now  = moving_hit || stopped_hit;
         rsp_data_in.alert_now     = window_expired;
         rsp_data_in.accident_mode = mode_in;
         rsp_data_in.confirmed     = window_expired;
      end
   end

   // advance control and detection state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         moving_running_ff  <= 1'b0;
         moving_start_ff    <= '0;
         stopped_running_ff <= 1'b0;
         stopped_start_ff   <= '0;
         triggered_ff       <= 1'b0;
         mode_ff            <= MODE_NONE;
         window_start_ff    <= '0;
         confirmed_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            rsp_valid_ff       <= 1'b1;
            moving_running_ff  <= moving_running_in;
            moving_start_ff    <= moving_start_in;
            stopped_running_ff <= stopped_running_in;
            stopped_start_ff   <= stopped_start_in;
            triggered_ff       <= triggered_in;
            mode_ff            <= mode_in;
            window_start_ff    <= window_start_in;
            confirmed_ff       <= confirmed_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // load payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks on the detection logic
   a_confirmed_needs_trigger: assert property (@(posedge clock) disable iff (reset)
      confirmed_ff |-> (triggered_ff && (mode_ff != MODE_NONE)))
      else $error("confirmed without a detected accident");

   a_alert_sets_confirmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.alert_now) |-> rsp_data_ff.confirmed)
      else $error("alert without confirmed");

   a_buzzer_excludes_confirmed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.buzzer_on && rsp_data_ff.confirmed))
      else $error("buzzer on while confirmed");

   a_detect_has_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.detected_now) |->
         (rsp_data_ff.accident_mode == MODE_MOVING ||
          rsp_data_ff.accident_mode == MODE_STOPPED))
      else $error("detection without an accident mode");

   a_trigger_holds: assert property (@(posedge clock) disable iff (reset)
      (triggered_ff && !s1_advance) |=> triggered_ff)
      else $error("trigger lost without a transfer");

endmodule
